>>> hw/rtl/skst_pkg.sv
// Shared types and constants of the sorted key set table.
package skst_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 23;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
  } skst_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              present;
    logic [CNT_W-1:0]  entry_count;
  } skst_out_t;

endpackage

>>> hw/rtl/skst_core.sv
// Key memory with the search, shift and update sequencer.
module skst_core
  import skst_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  skst_in_t  req_i,
  output logic      busy_o,
  output logic      res_valid_o,
  output skst_out_t res_o,
  input  logic      res_take_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_CHK,
    S_MV_RD,
    S_MV_WR,
    S_PUT,
    S_RM_RD,
    S_RM_WR,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [CNT_W-1:0]  lo_q, hi_q, ptr_q, count_q;
  logic [STAT_W-1:0] status_q;
  logic              present_q;

  logic [KEY_W-1:0]  mem [CAPACITY];
  logic [KEY_W-1:0]  rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              we;
  logic [IDX_W-1:0]  wa;
  logic [KEY_W-1:0]  wd;

  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  ptr_dec, ptr_inc;
  logic              less;

  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign ptr_dec = ptr_q - CNT_W'(1);
  assign ptr_inc = ptr_q + CNT_W'(1);
  assign less    = (cmd_q == CMD_INSERT) ? (rd_q <= key_q) : (rd_q < key_q);

  always_comb begin
    rd_addr = mid[IDX_W-1:0];
    we      = 1'b0;
    wa      = ptr_q[IDX_W-1:0];
    wd      = rd_q;
    case (state_q)
      S_SRCH: begin
        rd_addr = (lo_q < hi_q) ? mid[IDX_W-1:0] : lo_q[IDX_W-1:0];
      end
      S_MV_RD: rd_addr = ptr_dec[IDX_W-1:0];
      S_RM_RD: rd_addr = ptr_inc[IDX_W-1:0];
      S_MV_WR, S_RM_WR: we = 1'b1;
      S_PUT: begin
        we = 1'b1;
        wa = lo_q[IDX_W-1:0];
        wd = key_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      status_q  <= ST_OK;
      present_q <= 1'b0;
      cmd_q     <= CMD_INSERT;
      key_q     <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      ptr_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cmd_q     <= req_i.command;
            key_q     <= req_i.key;
            lo_q      <= '0;
            hi_q      <= count_q;
            status_q  <= ST_OK;
            present_q <= 1'b0;
            if (req_i.command == CMD_INSERT && count_q >= CNT_W'(CAPACITY)) begin
              status_q <= ST_FULL;
              state_q  <= S_DONE;
            end else if (req_i.command == CMD_INSERT || req_i.command == CMD_REMOVE ||
                         req_i.command == CMD_QUERY) begin
              state_q <= S_SRCH;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_SRCH: begin
          if (lo_q < hi_q) begin
            state_q <= S_CMP;
          end else if (cmd_q == CMD_INSERT) begin
            ptr_q   <= count_q;
            state_q <= S_MV_RD;
          end else if (lo_q < count_q) begin
            state_q <= S_CHK;
          end else begin
            if (cmd_q == CMD_REMOVE) begin
              status_q <= ST_NOT_FOUND;
            end
            state_q <= S_DONE;
          end
        end
        S_CMP: begin
          if (less) begin
            lo_q <= mid + CNT_W'(1);
          end else begin
            hi_q <= mid;
          end
          state_q <= S_SRCH;
        end
        S_CHK: begin
          if (cmd_q == CMD_QUERY) begin
            present_q <= (rd_q == key_q);
            state_q   <= S_DONE;
          end else if (rd_q == key_q) begin
            ptr_q   <= lo_q;
            state_q <= S_RM_RD;
          end else begin
            status_q <= ST_NOT_FOUND;
            state_q  <= S_DONE;
          end
        end
        S_MV_RD: begin
          state_q <= (ptr_q > lo_q) ? S_MV_WR : S_PUT;
        end
        S_MV_WR: begin
          ptr_q   <= ptr_dec;
          state_q <= S_MV_RD;
        end
        S_PUT: begin
          count_q <= count_q + CNT_W'(1);
          state_q <= S_DONE;
        end
        S_RM_RD: begin
          if (ptr_inc < count_q) begin
            state_q <= S_RM_WR;
          end else begin
            count_q <= count_q - CNT_W'(1);
            state_q <= S_DONE;
          end
        end
        S_RM_WR: begin
          ptr_q   <= ptr_inc;
          state_q <= S_RM_RD;
        end
        S_DONE: begin
          if (res_take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o            = (state_q != S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.status      = status_q;
  assign res_o.present     = present_q;
  assign res_o.entry_count = count_q;

endmodule

>>> hw/rtl/sorted_key_set_table_top.sv
// Top level of the sorted key set table: handshakes and output register.
//
//  channel  dir  payload     accepted when
//  in       in   skst_in_t   in_valid_i  && !in_stall_o
//  out      out  skst_out_t  out_valid_o && !out_stall_i
//
// An item goes through setup, a binary search over the single registered
// read port of the key memory, a move of each shifted entry on insert or
// remove, the update and the result, and then an idle state in which the
// next transaction is accepted.
// Reset clears the entry count; the key memory is left unwritten.
// A finished result waits in the output register while the next item runs.
module sorted_key_set_table_top
  import skst_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  skst_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output skst_out_t out_data_o
);

  logic      busy;
  logic      res_valid;
  skst_out_t res;
  logic      res_take;
  logic      out_valid_q;
  skst_out_t out_data_q;

  assign in_stall_o = busy;
  assign res_take   = res_valid && (!out_valid_q || !out_stall_i);

  skst_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && !busy),
    .req_i       (in_data_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_FULL) |->
      out_data_o.entry_count == CNT_W'(CAPACITY))
    else $error("full status with spare room");

  a_present_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.present) |-> out_data_o.status == ST_OK)
    else $error("present flag with error status");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepted transaction");
`endif

endmodule

>>> tb/sorted_key_set_table_top_test.sv
// Testbench of the sorted key set table: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module sorted_key_set_table_top_test;
  import skst_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX    = {KEY_W{1'b1}};
  localparam int DIR_N        = 20;
  localparam int BLOCK_N      = 20;
  localparam int BLOCK_LEN    = 80;
  localparam int DRAIN_CYCLES = 400;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    bit               typed;
    skst_out_t        exp;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  skst_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  skst_out_t out_data_o;

  logic [KEY_W-1:0] held_keys [CAPACITY];
  int               held_n;
  skst_out_t        pending_results [$];
  skst_out_t        want;
  dir_row_t         dir_rows [DIR_N];
  int               errors;
  int               stall_left;
  bit               calm;

  sorted_key_set_table_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic skst_out_t table_update(input logic [CMD_W-1:0] cmd,
                                             input logic [KEY_W-1:0] key);
    skst_out_t r;
    int        pos;
    r = '{status: ST_OK, present: 1'b0, entry_count: '0};
    case (cmd)
      CMD_INSERT: begin
        if (held_n >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = held_n;
          for (int i = 0; i < held_n; i++) begin
            if (held_keys[i] > key) begin
              pos = i;
              break;
            end
          end
          for (int i = held_n; i > pos; i--) held_keys[i] = held_keys[i-1];
          held_keys[pos] = key;
          held_n++;
        end
      end
      CMD_REMOVE: begin
        pos = -1;
        for (int i = 0; i < held_n; i++) begin
          if (held_keys[i] == key) begin
            pos = i;
            break;
          end
        end
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < held_n; i++) held_keys[i] = held_keys[i+1];
          held_n--;
        end
      end
      CMD_QUERY: begin
        for (int i = 0; i < held_n; i++) begin
          if (held_keys[i] == key) r.present = 1'b1;
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(held_n);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(input bit from_table);
    int r;
    r = $urandom_range(0, 99);
    if (from_table && held_n > 0 && r < 60) return held_keys[$urandom_range(0, held_n - 1)];
    r = $urandom_range(0, 99);
    if (r < 40) return KEY_W'($urandom_range(0, 15));
    if (r < 50) begin
      case ($urandom_range(0, 2))
        0:       return '0;
        1:       return KEY_MAX;
        default: return 23'h400000;
      endcase
    end
    return KEY_W'($urandom);
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input bit typed, input skst_out_t typed_exp);
    int        gap;
    skst_out_t pred;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= '{command: cmd, key: key};
    do @(posedge clk_i); while (in_stall_o);
    pred = table_update(cmd, key);
    pending_results.push_back(typed ? typed_exp : pred);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2) : $urandom_range(9, 39);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected transaction: status %0d present %0d count %0d",
                   out_data_o.status, out_data_o.present, out_data_o.entry_count);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status || out_data_o.present !== want.present ||
            out_data_o.entry_count !== want.entry_count) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch: exp status %0d present %0d count %0d, got %0d %0d %0d",
                     want.status, want.present, want.entry_count,
                     out_data_o.status, out_data_o.present, out_data_o.entry_count);
        end
      end
    end
  end

  initial begin
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    int               r;
    int               mode;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    rst_ni      = 1'b0;
    calm        = 1'b0;
    held_n      = 0;
    dir_rows = '{
      '{CMD_QUERY,   '0,          1'b1, '{ST_OK,        1'b0, CNT_W'(0)}},
      '{CMD_REMOVE,  '0,          1'b1, '{ST_NOT_FOUND, 1'b0, CNT_W'(0)}},
      '{CMD_UNUSED,  KEY_MAX,     1'b1, '{ST_OK,        1'b0, CNT_W'(0)}},
      '{CMD_INSERT,  '0,          1'b1, '{ST_OK,        1'b0, CNT_W'(1)}},
      '{CMD_INSERT,  KEY_MAX,     1'b1, '{ST_OK,        1'b0, CNT_W'(2)}},
      '{CMD_QUERY,   KEY_MAX,     1'b1, '{ST_OK,        1'b1, CNT_W'(2)}},
      '{CMD_QUERY,   '0,          1'b1, '{ST_OK,        1'b1, CNT_W'(2)}},
      '{CMD_INSERT,  23'd5,       1'b0, '0},
      '{CMD_INSERT,  23'd5,       1'b0, '0},
      '{CMD_INSERT,  23'd3,       1'b0, '0},
      '{CMD_QUERY,   23'd4,       1'b0, '0},
      '{CMD_REMOVE,  23'd5,       1'b0, '0},
      '{CMD_QUERY,   23'd5,       1'b0, '0},
      '{CMD_REMOVE,  23'd5,       1'b0, '0},
      '{CMD_REMOVE,  23'd5,       1'b0, '0},
      '{CMD_UNUSED,  23'd5,       1'b0, '0},
      '{CMD_INSERT,  23'h2AAAAA,  1'b0, '0},
      '{CMD_INSERT,  23'h555555,  1'b0, '0},
      '{CMD_REMOVE,  KEY_MAX,     1'b0, '0},
      '{CMD_QUERY,   23'h400000,  1'b0, '0}
    };
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_N; i++)
      send_item(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].exp);

    for (int blk = 0; blk < BLOCK_N; blk++) begin
      calm = (blk % 5 == 4);
      mode = blk % 4;
      for (int j = 0; j < BLOCK_LEN; j++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0:       cmd = (r < 90) ? CMD_INSERT : (r < 96) ? CMD_QUERY : CMD_REMOVE;
          1:       cmd = (r < 40) ? CMD_INSERT : (r < 75) ? CMD_REMOVE : CMD_QUERY;
          2:       cmd = (r < 80) ? CMD_REMOVE : (r < 92) ? CMD_QUERY : CMD_INSERT;
          default: cmd = CMD_W'($urandom_range(0, 3));
        endcase
        key = pick_key(cmd != CMD_INSERT);
        send_item(cmd, key, 1'b0, '0);
      end
    end
    calm = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
